// ===== rtl/bdlp_pkg.sv =====
// bdlp_pkg: shared types and constants for the button debounce / long press core
// no dependencies
package bdlp_pkg;

    localparam int TICKS_W = 16;
    localparam logic [TICKS_W-1:0] LONG_PRESS_RESET = 16'd2000;

    typedef enum logic [1:0] {
        MODE_TICK         = 2'd0,
        MODE_TAKE_PRESS   = 2'd1,
        MODE_TAKE_RELEASE = 2'd2,
        MODE_TAKE_LONG    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode mode;
        logic  switch_level;
    } t_item;

    typedef struct packed {
        logic event_res;
        logic held;
        logic pressed_pending;
        logic released_pending;
        logic long_pending;
    } t_result;

endpackage

// ===== rtl/bdlp_in_reg.sv =====
// bdlp_in_reg: input register stage holding one accepted beat
// depends on bdlp_pkg
module bdlp_in_reg import bdlp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_item i_item,
    input  logic  i_out_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign o_in_stall = r_valid && !i_out_ready;
    assign w_load     = !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/bdlp_engine.sv =====
// bdlp_engine: debounce integrator, event flags, hold counter and threshold register
// depends on bdlp_pkg
module bdlp_engine import bdlp_pkg::*; #(
    parameter int INTEGRATOR_TOP = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICKS_W-1:0] i_cfg_wdata,
    input  logic               i_fire,
    input  t_item              i_item,
    output t_result            o_result
);

    localparam int IW = $clog2(INTEGRATOR_TOP + 1);
    localparam logic [IW-1:0] TOP_V     = IW'(INTEGRATOR_TOP);
    localparam logic [IW-1:0] TOP_M1_V  = IW'(INTEGRATOR_TOP - 1);
    localparam logic [IW-1:0] ONE_V     = IW'(1);
    localparam logic [IW-1:0] TWO_V     = IW'(2);
    localparam logic [IW:0]   TWO_EXT   = (IW+1)'(2);
    localparam logic [IW:0]   TOP_M1_EXT = (IW+1)'(INTEGRATOR_TOP - 1);

    logic [TICKS_W-1:0] r_ticks;
    logic [IW-1:0]      r_int, n_int;
    logic               r_held, n_held;
    logic               r_press, n_press;
    logic               r_release, n_release;
    logic [TICKS_W-1:0] r_hold, n_hold;

    logic [IW:0]        w_sum;
    logic [TICKS_W:0]   w_hold_inc;
    logic               w_ev;

    always_comb begin
        n_int     = r_int;
        n_held    = r_held;
        n_press   = r_press;
        n_release = r_release;
        n_hold    = r_hold;
        w_ev      = 1'b0;
        w_sum     = '0;
        w_hold_inc = '0;
        case (i_item.mode)
            MODE_TICK: begin
                if (i_item.switch_level) begin
                    w_sum = {1'b0, r_int} + (IW+1)'(1);
                end else if (r_int != '0) begin
                    w_sum = {1'b0, r_int} - (IW+1)'(1);
                end
                if (w_sum < TWO_EXT) begin
                    if (r_int == TWO_V) begin
                        n_press = 1'b1;
                    end
                    n_int  = ONE_V;
                    n_held = 1'b1;
                end else if (w_sum > TOP_M1_EXT) begin
                    if (r_int == TOP_M1_V) begin
                        n_release = 1'b1;
                    end
                    n_int  = TOP_V;
                    n_held = 1'b0;
                end else begin
                    n_int = w_sum[IW-1:0];
                end
                if (n_held) begin
                    w_hold_inc = {1'b0, r_hold} + (TICKS_W+1)'(1);
                end
                if (w_hold_inc >= {1'b0, r_ticks}) begin
                    n_hold = r_ticks;
                end else begin
                    n_hold = w_hold_inc[TICKS_W-1:0];
                end
            end
            MODE_TAKE_PRESS: begin
                w_ev    = r_press;
                n_press = 1'b0;
            end
            MODE_TAKE_RELEASE: begin
                w_ev      = r_release;
                n_release = 1'b0;
            end
            MODE_TAKE_LONG: begin
                if (r_hold >= r_ticks) begin
                    n_hold = '0;
                    w_ev   = 1'b1;
                end
            end
            default: begin
                w_ev = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= LONG_PRESS_RESET;
            r_int     <= TOP_V;
            r_held    <= 1'b0;
            r_press   <= 1'b0;
            r_release <= 1'b0;
            r_hold    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ticks <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_int     <= n_int;
                r_held    <= n_held;
                r_press   <= n_press;
                r_release <= n_release;
                r_hold    <= n_hold;
            end
        end
    end

    assign o_result.event_res        = w_ev;
    assign o_result.held             = n_held;
    assign o_result.pressed_pending  = n_press;
    assign o_result.released_pending = n_release;
    assign o_result.long_pending     = (n_hold >= r_ticks);

endmodule

// ===== rtl/bdlp_out_reg.sv =====
// bdlp_out_reg: result register on the output channel
// depends on bdlp_pkg
module bdlp_out_reg import bdlp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

// ===== rtl/button_debounce_long_press_core.sv =====
// button_debounce_long_press_core: top level of the integrating debouncer with long press
// depends on bdlp_pkg, bdlp_in_reg, bdlp_engine, bdlp_out_reg
//
// Takes one beat per clock while the input is not stalled and returns exactly one result
// beat for each. An accepted beat is held in the input register, and the integrator, flags
// and hold counter update as it moves on into the result register, where the result is
// shown until it is taken. A stalled result holds and, once the input register is also
// full, stalls the input. A tick (mode 0) moves the integrator; level 0 counts toward
// pressed. Modes 1, 2 and 3 read and clear the press, release and long press events. The
// user must write the long press threshold register through i_cfg_we / i_cfg_wdata while
// no beat is in flight; the core itself does not enforce this.
module button_debounce_long_press_core import bdlp_pkg::*; #(
    parameter int INTEGRATOR_TOP = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICKS_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic               i_switch_level,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_event_res,
    output logic               o_held,
    output logic               o_pressed_pending,
    output logic               o_released_pending,
    output logic               o_long_pending
);

    t_item   w_in_item;
    t_item   w_stage_item;
    logic    w_stage_valid;
    logic    w_out_ready;
    t_result w_result;
    t_result w_out_result;

    assign w_in_item.mode         = t_mode'(i_mode);
    assign w_in_item.switch_level = i_switch_level;

    bdlp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (w_in_item),
        .i_out_ready (w_out_ready),
        .o_valid     (w_stage_valid),
        .o_item      (w_stage_item)
    );

    bdlp_engine #(
        .INTEGRATOR_TOP (INTEGRATOR_TOP)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_stage_valid && w_out_ready),
        .i_item      (w_stage_item),
        .o_result    (w_result)
    );

    bdlp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_stage_valid),
        .i_result    (w_result),
        .o_ready     (w_out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_out_result)
    );

    assign o_event_res        = w_out_result.event_res;
    assign o_held             = w_out_result.held;
    assign o_pressed_pending  = w_out_result.pressed_pending;
    assign o_released_pending = w_out_result.released_pending;
    assign o_long_pending     = w_out_result.long_pending;

endmodule

// ===== rtl/bdlp_checker.sv =====
// bdlp_port_checker: port-level assertions for the debounce core, bound to the top level
// depends on button_debounce_long_press_core
module bdlp_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_event_res,
    input logic o_held,
    input logic o_pressed_pending,
    input logic o_released_pending,
    input logic o_long_pending
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown right after reset");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted beat did not reach the output in two cycles");

    a_hold_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_event_res)
            && $stable(o_held) && $stable(o_pressed_pending)
            && $stable(o_released_pending) && $stable(o_long_pending)))
        else $error("stalled result beat changed");

endmodule

bind button_debounce_long_press_core bdlp_port_checker u_bdlp_port_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_event_res        (o_event_res),
    .o_held             (o_held),
    .o_pressed_pending  (o_pressed_pending),
    .o_released_pending (o_released_pending),
    .o_long_pending     (o_long_pending)
);

// ===== tb/bdlp_checker.sv =====
// bdlp_checker: watches the item, result and config ports of the debounce core,
// predicts every result beat and compares all its fields at once; depends on bdlp_pkg
`timescale 1ns / 1ps

module bdlp_checker import bdlp_pkg::*; #(
    parameter int INTEGRATOR_TOP = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICKS_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic               i_switch_level,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_event_res,
    input  logic               i_held,
    input  logic               i_pressed_pending,
    input  logic               i_released_pending,
    input  logic               i_long_pending,
    output int                 o_errors,
    output int                 o_pending
);

    int unsigned        integ;
    int unsigned        prev_integ;
    int unsigned        hold_cnt;
    logic               held_q;
    logic               press_q;
    logic               release_q;
    logic [TICKS_W-1:0] long_thresh;
    t_result            status_q[$];
    int                 mismatch_cnt = 0;

    function automatic t_result debounce_step(input t_mode m, input logic lvl);
        t_result     r;
        int unsigned v;
        r = '0;
        case (m)
            MODE_TICK: begin
                v = integ;
                if (lvl) begin
                    v = v + 1;
                end else begin
                    v = (v > 0) ? v - 1 : 0;
                end
                if (v < 2) begin
                    if (prev_integ == 2) press_q = 1'b1;
                    v      = 1;
                    held_q = 1'b1;
                end else if (v > INTEGRATOR_TOP - 1) begin
                    if (prev_integ == INTEGRATOR_TOP - 1) release_q = 1'b1;
                    v      = INTEGRATOR_TOP;
                    held_q = 1'b0;
                end
                hold_cnt   = held_q ? hold_cnt + 1 : 0;
                integ      = v;
                prev_integ = v;
                if (hold_cnt >= long_thresh) hold_cnt = long_thresh;
            end
            MODE_TAKE_PRESS: begin
                r.event_res = press_q;
                press_q     = 1'b0;
            end
            MODE_TAKE_RELEASE: begin
                r.event_res = release_q;
                release_q   = 1'b0;
            end
            default: begin
                if (hold_cnt >= long_thresh) begin
                    hold_cnt    = 0;
                    r.event_res = 1'b1;
                end
            end
        endcase
        r.held             = held_q;
        r.pressed_pending  = press_q;
        r.released_pending = release_q;
        r.long_pending     = (hold_cnt >= long_thresh);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            integ       = INTEGRATOR_TOP;
            prev_integ  = INTEGRATOR_TOP;
            hold_cnt    = 0;
            held_q      = 1'b0;
            press_q     = 1'b0;
            release_q   = 1'b0;
            long_thresh = LONG_PRESS_RESET;
            status_q.delete();
        end else begin
            if (i_cfg_we) long_thresh = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(debounce_step(t_mode'(i_mode), i_switch_level));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_event_res, i_held, i_pressed_pending, i_released_pending,
                        i_long_pending};
                if (status_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: result beat with none expected, ev/held/prs/rel/long=%b",
                                 $realtime, got);
                    end
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: mismatch ev/held/prs/rel/long expected %b actual %b",
                                     $realtime, want, got);
                        end
                    end
                end
            end
        end
        o_pending <= status_q.size();
        o_errors  <= mismatch_cnt;
    end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: drives items and threshold writes into button_debounce_long_press_core
// with random idling and stalls; depends on bdlp_pkg, bdlp_checker and the core
`timescale 1ns / 1ps

module tb_top import bdlp_pkg::*;;

    localparam int CYCLE_LIMIT = 300000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [TICKS_W-1:0] cfg_wdata    = '0;
    logic               in_valid     = 1'b0;
    logic [1:0]         mode         = MODE_TICK;
    logic               switch_level = 1'b0;
    logic               out_stall    = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               event_res;
    logic               held;
    logic               pressed_pending;
    logic               released_pending;
    logic               long_pending;
    int                 errors;
    int                 pending;

    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 hold_req      = 0;
    int                 hold_seen     = 0;
    int                 hold_left     = 0;
    int                 cycle_cnt     = 0;
    int                 beat_cnt      = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    button_debounce_long_press_core u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_mode             (mode),
        .i_switch_level     (switch_level),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_event_res        (event_res),
        .o_held             (held),
        .o_pressed_pending  (pressed_pending),
        .o_released_pending (released_pending),
        .o_long_pending     (long_pending)
    );

    bdlp_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_mode             (mode),
        .i_switch_level     (switch_level),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_event_res        (event_res),
        .i_held             (held),
        .i_pressed_pending  (pressed_pending),
        .i_released_pending (released_pending),
        .i_long_pending     (long_pending),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    // receiver stalls, with a long hold-off on request
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 64;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_beat(input t_mode m, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        switch_level <= lvl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beat_cnt++;
    endtask

    task automatic write_threshold(input logic [TICKS_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ticks toward one level, with bounce and an occasional query mixed in
    task automatic level_run(input logic lvl, input int n, input int bounce_pct);
        logic q_lvl;
        repeat (n) begin
            if ($urandom_range(7) == 0) begin
                q_lvl = 1'($urandom_range(1));
                send_beat(t_mode'($urandom_range(1, 3)), q_lvl);
            end
            send_beat(MODE_TICK, ($urandom_range(99) < bounce_pct) ? ~lvl : lvl);
        end
    endtask

    task automatic random_episode();
        int   kind;
        int   n;
        logic lvl;
        kind = $urandom_range(9);
        if (kind < 2) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                lvl = 1'($urandom_range(1));
                send_beat(MODE_TICK, lvl);
            end
        end else if (kind < 4) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                lvl = 1'($urandom_range(1));
                send_beat(t_mode'($urandom_range(1, 3)), lvl);
            end
        end else if (kind < 7) begin
            level_run(1'b0, $urandom_range(30, 48), 10);
        end else begin
            level_run(1'b1, $urandom_range(30, 42), 10);
        end
    endtask

    initial begin
        int phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 25;
        recv_idle_pct <= 83;
        @(posedge clk);

        // queries at reset and clamping at the released end
        send_beat(MODE_TAKE_PRESS, 1'b0);
        send_beat(MODE_TAKE_RELEASE, 1'b1);
        send_beat(MODE_TAKE_LONG, 1'b0);
        send_beat(MODE_TICK, 1'b1);
        send_beat(MODE_TICK, 1'b1);

        // zero threshold, release edge without a press
        write_threshold('0);
        send_beat(MODE_TAKE_LONG, 1'b1);
        send_beat(MODE_TAKE_LONG, 1'b0);
        send_beat(MODE_TICK, 1'b0);
        send_beat(MODE_TICK, 1'b1);
        send_beat(MODE_TAKE_RELEASE, 1'b0);
        send_beat(MODE_TAKE_RELEASE, 1'b1);
        send_beat(MODE_TAKE_PRESS, 1'b1);

        // full press with clamping at the held end, then threshold lowered under the count
        write_threshold('1);
        level_run(1'b0, 40, 0);
        send_beat(MODE_TAKE_PRESS, 1'b0);
        write_threshold(16'd4);
        send_beat(MODE_TICK, 1'b0);
        send_beat(MODE_TAKE_LONG, 1'b1);
        send_beat(MODE_TAKE_LONG, 1'b0);
        level_run(1'b1, 40, 0);
        send_beat(MODE_TAKE_RELEASE, 1'b0);

        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_idle_pct <= 83;
                recv_idle_pct <= 25;
            end else if (p == 6) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            write_threshold((p == 1) ? 16'd1 : (p == 2) ? 16'hFFFF : (p == 4) ? 16'd0 :
                            (p == 7) ? LONG_PRESS_RESET : 16'($urandom_range(2, 25)));
            if (p == 1 || p == 6) hold_req <= hold_req + 1;
            phase_start = beat_cnt;
            while (beat_cnt - phase_start < 50) random_episode();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
